// File: rtl/lpcp_pkg.sv
package lpcp_pkg;

	// Geometry and field widths
	localparam int NUM_CAMERAS = 4;
	localparam int COORD_BITS  = 20;
	localparam int CW          = COORD_BITS + 3;      // camera-frame coordinate, signed
	localparam int CFG_W       = 16;
	localparam int SIZE_W      = 13;
	localparam int PIX_W       = 12;
	localparam int TAG_W       = 17;
	localparam int CAM_W       = 2;
	localparam int OUTC_W      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CAM_IW      = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;

	// Divider and numerator sizing
	localparam int QBITS = PIX_W;                     // one quotient bit per divider stage
	localparam int NUM_W = CFG_W + CW + 2;            // focal*x + center*z, signed
	localparam int DIV_W = CW - 1 + QBITS;            // dividend below depth << QBITS
	localparam int LAT   = 4 + QBITS;                 // transform, product, sum, range, divide

	// Stream word widths
	localparam int S_DATA_W = ((3 * COORD_BITS + TAG_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((2 * PIX_W + TAG_W + 7) / 8) * 8;

	localparam logic [SIZE_W-1:0] MAX_IMAGE = SIZE_W'(4096);

	// Outcome codes
	localparam logic [OUTC_W-1:0] OUT_INSIDE  = OUTC_W'(0);
	localparam logic [OUTC_W-1:0] OUT_BEHIND  = OUTC_W'(1);
	localparam logic [OUTC_W-1:0] OUT_OUTSIDE = OUTC_W'(2);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(5);

	// Register reset values
	localparam logic [CFG_W-1:0]  FOCAL_X_RST      = CFG_W'(512);
	localparam logic [CFG_W-1:0]  FOCAL_Y_RST      = CFG_W'(512);
	localparam logic [CFG_W-1:0]  CENTER_X_RST     = CFG_W'(512);
	localparam logic [CFG_W-1:0]  CENTER_Y_RST     = CFG_W'(384);
	localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST  = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST = SIZE_W'(768);

	// Extrinsic ROM: rotation entries are +1, -1 or 0
	localparam logic signed [1:0] R_P = 2'sb01;
	localparam logic signed [1:0] R_N = 2'sb11;
	localparam logic signed [1:0] R_0 = 2'sb00;

	localparam logic signed [1:0] ROT [NUM_CAMERAS][3][3] = '{
		'{ '{R_0, R_N, R_0}, '{R_0, R_0, R_N}, '{R_P, R_0, R_0} },
		'{ '{R_P, R_0, R_0}, '{R_0, R_0, R_N}, '{R_0, R_P, R_0} },
		'{ '{R_N, R_0, R_0}, '{R_0, R_0, R_N}, '{R_0, R_N, R_0} },
		'{ '{R_0, R_P, R_0}, '{R_0, R_0, R_N}, '{R_N, R_0, R_0} }
	};

	// Translations in 1/1024 m
	localparam logic signed [CW-1:0] TRANS [NUM_CAMERAS][3] = '{
		'{ CW'(0), CW'(-410),  CW'(-2048) },
		'{ CW'(0), CW'(-1434), CW'(-1024) },
		'{ CW'(0), CW'(-1434), CW'(-1024) },
		'{ CW'(0), CW'(-410),  CW'(-2048) }
	};

	typedef struct packed {
		logic [CFG_W-1:0]  focal_x;
		logic [CFG_W-1:0]  focal_y;
		logic [CFG_W-1:0]  center_x;
		logic [CFG_W-1:0]  center_y;
		logic [SIZE_W-1:0] image_width;
		logic [SIZE_W-1:0] image_height;
	} cfg_t;

	// Sideband that rides along the pipeline with each word
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic              early;    // outcome already settled
		logic [OUTC_W-1:0] code;     // settled outcome when early
	} side_t;

	typedef struct packed {
		logic [OUTC_W-1:0] outcome;
		logic [PIX_W-1:0]  pixel_u;
		logic [PIX_W-1:0]  pixel_v;
		logic [TAG_W-1:0]  tag_out;
	} res_t;

endpackage

// File: rtl/lpcp_xform.sv
module lpcp_xform (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [lpcp_pkg::CAM_W-1:0]            camera,
	input  logic signed [lpcp_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [lpcp_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [lpcp_pkg::COORD_BITS-1:0] point_z,
	input  logic [lpcp_pkg::TAG_W-1:0]            point_tag,
	output logic signed [lpcp_pkg::CW-1:0]        xc_s1,
	output logic signed [lpcp_pkg::CW-1:0]        yc_s1,
	output logic signed [lpcp_pkg::CW-1:0]        zc_s1,
	output lpcp_pkg::side_t                       side_s1
);
	import lpcp_pkg::*;

	function automatic logic signed [CW-1:0] rot_term(
		input logic signed [1:0]            r,
		input logic signed [COORD_BITS-1:0] p
	);
		logic signed [CW-1:0] t;
		case (r)
			R_P:     t = CW'(p);
			R_N:     t = -CW'(p);
			default: t = '0;
		endcase
		return t;
	endfunction

	logic                        cam_ok;
	logic [CAM_IW-1:0]           cam_idx;
	logic signed [COORD_BITS-1:0] p [3];
	logic signed [CW-1:0]        c [3];
	logic                        behind;
	side_t                       side;

	always_comb begin
		cam_ok  = {1'b0, camera} < (CAM_W + 1)'(NUM_CAMERAS);
		cam_idx = cam_ok ? CAM_IW'(camera) : '0;
		p[0] = point_x;
		p[1] = point_y;
		p[2] = point_z;
		for (int r = 0; r < 3; r++) begin
			c[r] = TRANS[cam_idx][r];
			for (int k = 0; k < 3; k++) begin
				c[r] = c[r] + rot_term(ROT[cam_idx][r][k], p[k]);
			end
		end
		behind     = c[2][CW-1] || (c[2] == '0);
		side.tag   = point_tag;
		side.early = !cam_ok || behind;
		side.code  = cam_ok ? OUT_BEHIND : OUT_OUTSIDE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s1   <= c[0];
			yc_s1   <= c[1];
			zc_s1   <= c[2];
			side_s1 <= side;
		end
	end

endmodule

// File: rtl/lpcp_lane.sv
module lpcp_lane (
	input  logic                            clk,
	input  logic                            en,
	input  logic [lpcp_pkg::CFG_W-1:0]      focal,
	input  logic [lpcp_pkg::CFG_W-1:0]      center,
	input  logic signed [lpcp_pkg::CW-1:0]  coord,
	input  logic signed [lpcp_pkg::CW-1:0]  depth,
	output logic [lpcp_pkg::DIV_W-1:0]      dvd_s4,
	output logic [lpcp_pkg::CW-2:0]         den_s4,
	output logic                            fail_s4
);
	import lpcp_pkg::*;

	logic signed [NUM_W-2:0] fa, ca, ma, za;
	logic signed [NUM_W-2:0] prod_c_s2, prod_z_s2;
	logic [CW-2:0]           den_s2, den_s3;
	logic signed [NUM_W-1:0] num_s3;
	logic [NUM_W-1:0]        den_ext, lift, lim;
	logic                    neg, near_zero, below, fail;
	logic [DIV_W-1:0]        dvd;

	assign fa = (NUM_W - 1)'(focal);
	assign ca = (NUM_W - 1)'(coord);
	assign ma = (NUM_W - 1)'(center);
	assign za = (NUM_W - 1)'(depth);

	// Products
	always_ff @(posedge clk) begin
		if (en) begin
			prod_c_s2 <= fa * ca;
			prod_z_s2 <= ma * za;
			den_s2    <= depth[CW-2:0];
		end
	end

	// Numerator
	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= NUM_W'(prod_c_s2) + NUM_W'(prod_z_s2);
			den_s3 <= den_s2;
		end
	end

	// Range check: a negative numerator smaller than the depth truncates to
	// zero; otherwise the quotient must fit in the pixel width.
	always_comb begin
		den_ext   = NUM_W'(den_s3);
		neg       = num_s3[NUM_W-1];
		lift      = num_s3 + den_ext;
		near_zero = !lift[NUM_W-1] && (lift != '0);
		lim       = den_ext << QBITS;
		below     = $unsigned(num_s3) < lim;
		fail      = neg ? !near_zero : !below;
		dvd       = neg ? '0 : num_s3[DIV_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s4  <= dvd;
			den_s4  <= den_s3;
			fail_s4 <= fail;
		end
	end

endmodule

// File: rtl/lpcp_divider.sv
module lpcp_divider (
	input  logic                        clk,
	input  logic                        en,
	input  logic [lpcp_pkg::DIV_W-1:0]  dvd,
	input  logic [lpcp_pkg::CW-2:0]     den,
	output logic [lpcp_pkg::QBITS-1:0]  quo
);
	import lpcp_pkg::*;

	logic [DIV_W-1:0] rem_s [QBITS-1];
	logic [CW-2:0]    den_s [QBITS-1];
	logic [QBITS-1:0] quo_s [QBITS];

	logic [DIV_W-1:0] rem_in [QBITS];
	logic [CW-2:0]    den_in [QBITS];
	logic [QBITS-1:0] quo_in [QBITS];
	logic [DIV_W:0]   trial  [QBITS];

	// Restoring division, most significant quotient bit first
	always_comb begin
		rem_in[0] = dvd;
		den_in[0] = den;
		quo_in[0] = '0;
		for (int j = 1; j < QBITS; j++) begin
			rem_in[j] = rem_s[j-1];
			den_in[j] = den_s[j-1];
			quo_in[j] = quo_s[j-1];
		end
		for (int j = 0; j < QBITS; j++) begin
			trial[j] = {1'b0, rem_in[j]} - ((DIV_W + 1)'(den_in[j]) << (QBITS - 1 - j));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < QBITS - 1; j++) begin
				rem_s[j] <= trial[j][DIV_W] ? rem_in[j] : trial[j][DIV_W-1:0];
				den_s[j] <= den_in[j];
			end
			for (int j = 0; j < QBITS; j++) begin
				quo_s[j] <= {quo_in[j][QBITS-2:0], !trial[j][DIV_W]};
			end
		end
	end

	assign quo = quo_s[QBITS-1];

endmodule

// File: rtl/lpcp_outbuf.sv
module lpcp_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  lpcp_pkg::res_t   in_res,
	output logic             en,
	output logic             out_vld,
	input  logic             out_rdy,
	output lpcp_pkg::res_t   out_res
);
	import lpcp_pkg::*;

	logic out_vld_q, skid_vld_q;
	res_t out_res_q, skid_res_q;
	logic out_free, take;

	// Advance the pipeline whenever the skid slot is free
	assign en       = !skid_vld_q;
	assign take     = in_vld && en;
	assign out_free = !out_vld_q || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q  <= skid_vld_q || take;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_res_q <= skid_vld_q ? skid_res_q : in_res;
		end else if (take) begin
			skid_res_q <= in_res;
		end
	end

	assign out_vld = out_vld_q;
	assign out_res = out_res_q;

endmodule

// File: rtl/lidar_point_camera_projection_unit.sv
// Lidar point to camera pixel projection. Each input word carries one lidar
// point (x, y, z in signed 1/1024 m) with a camera number and a scan tag; the
// point is moved into that camera's frame with a fixed extrinsic ROM, rejected
// as behind the camera when its depth is zero or less, and otherwise projected
// with u = trunc((focal_x*xc + center_x*zc)/zc), v likewise, then checked
// against the configured image size (sizes above 4096 act as 4096). One result
// word comes out for every input word, in order. The block takes one word per
// clock while the output buffer has room; a word passes through the pipeline
// stages (transform, products, sums, range check, then a 12-stage restoring
// divider that yields one pixel bit per stage) and then the output register.
// A two-entry output buffer keeps input ready independent of output ready, so
// input stalls only once a held output has filled both entries. Write the
// focal, center and image-size registers only while no words are in flight.
module lidar_point_camera_projection_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// point_x, point_y, point_z, point_tag (from bit 0 up), zero padded
	input  logic [lpcp_pkg::S_DATA_W-1:0]      s_tdata,
	// camera
	input  logic [lpcp_pkg::CAM_W-1:0]         s_tuser,
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pixel_u, pixel_v, tag_out (from bit 0 up), zero padded
	output logic [lpcp_pkg::M_DATA_W-1:0]      m_tdata,
	// outcome
	output logic [lpcp_pkg::OUTC_W-1:0]        m_tuser,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [lpcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpcp_pkg::CFG_W-1:0]         cfg_wdata
);
	import lpcp_pkg::*;

	cfg_t cfg_q;

	logic                        en;
	logic signed [CW-1:0]        xc_s1, yc_s1, zc_s1;
	side_t                       side_s1;
	logic                        vld_s  [LAT];      // index k holds stage k+1
	side_t                       side_d [LAT-1];    // index k holds stage k+2
	logic [DIV_W-1:0]            dvd_u_s4, dvd_v_s4;
	logic [CW-2:0]               den_u_s4, den_v_s4;
	logic                        fail_u_s4, fail_v_s4;
	logic [QBITS-1:0]            quo_u, quo_v;
	logic [SIZE_W-1:0]           w_cap, h_cap;
	logic                        in_frame;
	side_t                       fin;
	res_t                        res, out_res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x      <= FOCAL_X_RST;
			cfg_q.focal_y      <= FOCAL_Y_RST;
			cfg_q.center_x     <= CENTER_X_RST;
			cfg_q.center_y     <= CENTER_Y_RST;
			cfg_q.image_width  <= IMAGE_WIDTH_RST;
			cfg_q.image_height <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL_X:      cfg_q.focal_x      <= cfg_wdata;
				REG_FOCAL_Y:      cfg_q.focal_y      <= cfg_wdata;
				REG_CENTER_X:     cfg_q.center_x     <= cfg_wdata;
				REG_CENTER_Y:     cfg_q.center_y     <= cfg_wdata;
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata[SIZE_W-1:0];
				default: ;        // drop writes to unused indexes
			endcase
		end
	end

	// The whole pipeline moves as one; the output buffer decides when
	assign s_tready = en;

	// Stage 1: rotate and translate into the camera frame
	lpcp_xform u_xform (
		.clk       (clk),
		.en        (en),
		.camera    (s_tuser),
		.point_x   (s_tdata[COORD_BITS-1:0]),
		.point_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.point_z   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.point_tag (s_tdata[3*COORD_BITS+TAG_W-1:3*COORD_BITS]),
		.xc_s1     (xc_s1),
		.yc_s1     (yc_s1),
		.zc_s1     (zc_s1),
		.side_s1   (side_s1)
	);

	// Stages 2 to 4: numerators and range check, one lane per axis
	lpcp_lane u_lane_u (
		.clk     (clk),
		.en      (en),
		.focal   (cfg_q.focal_x),
		.center  (cfg_q.center_x),
		.coord   (xc_s1),
		.depth   (zc_s1),
		.dvd_s4  (dvd_u_s4),
		.den_s4  (den_u_s4),
		.fail_s4 (fail_u_s4)
	);

	lpcp_lane u_lane_v (
		.clk     (clk),
		.en      (en),
		.focal   (cfg_q.focal_y),
		.center  (cfg_q.center_y),
		.coord   (yc_s1),
		.depth   (zc_s1),
		.dvd_s4  (dvd_v_s4),
		.den_s4  (den_v_s4),
		.fail_s4 (fail_v_s4)
	);

	// Stages 5 to 16: pixel column and row by pipelined division
	lpcp_divider u_div_u (
		.clk (clk),
		.en  (en),
		.dvd (dvd_u_s4),
		.den (den_u_s4),
		.quo (quo_u)
	);

	lpcp_divider u_div_v (
		.clk (clk),
		.en  (en),
		.dvd (dvd_v_s4),
		.den (den_v_s4),
		.quo (quo_v)
	);

	// Valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int k = 1; k < LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Sideband; fold in the range check as it leaves stage 4
	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s1;
			for (int k = 1; k < LAT - 1; k++) begin
				if (k != 3) begin
					side_d[k] <= side_d[k-1];
				end
			end
			side_d[3].tag   <= side_d[2].tag;
			side_d[3].early <= side_d[2].early || fail_u_s4 || fail_v_s4;
			side_d[3].code  <= side_d[2].early ? side_d[2].code : OUT_OUTSIDE;
		end
	end

	// Final in-frame test on the quotients
	always_comb begin
		fin   = side_d[LAT-2];
		w_cap = (cfg_q.image_width > MAX_IMAGE) ? MAX_IMAGE : cfg_q.image_width;
		h_cap = (cfg_q.image_height > MAX_IMAGE) ? MAX_IMAGE : cfg_q.image_height;
		in_frame = !fin.early && (SIZE_W'(quo_u) < w_cap) && (SIZE_W'(quo_v) < h_cap);
		res.outcome = fin.early ? fin.code : (in_frame ? OUT_INSIDE : OUT_OUTSIDE);
		res.pixel_u = in_frame ? quo_u : '0;
		res.pixel_v = in_frame ? quo_v : '0;
		res.tag_out = fin.tag;
	end

	// Output register plus skid slot
	lpcp_outbuf u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s[LAT-1]),
		.in_res  (res),
		.en      (en),
		.out_vld (m_tvalid),
		.out_rdy (m_tready),
		.out_res (out_res)
	);

	assign m_tdata = M_DATA_W'({out_res.tag_out, out_res.pixel_v, out_res.pixel_u});
	assign m_tuser = out_res.outcome;

endmodule

// File: rtl/lpcp_checker.sv
module lpcp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [lpcp_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [lpcp_pkg::OUTC_W-1:0]    m_tuser
);
	import lpcp_pkg::*;

	// Hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// Pixels are zero unless the point lands inside the image
	a_zero_pix: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != OUT_INSIDE) |-> m_tdata[2*PIX_W-1:0] == '0)
		else $error("pixel reported for a point outside the image");

	// Input backpressure only follows an output that was held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

	// No result word once reset has been seen at an edge
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result word valid during reset");

endmodule

bind lidar_point_camera_projection_unit lpcp_checker u_lpcp_checker (.*);
